// ===== sv/rsl_pkg.sv =====
package rsl_pkg;

  // Fixed field widths
  localparam int RPM_W   = 16;
  localparam int MS_W    = 32;
  localparam int PIX_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W  = 3;

  // Serial divider: 32-bit dividend, 16-bit divisor
  localparam int DIVD_W = 32;
  localparam int DIVS_W = 16;
  localparam int DCNT_W = 6;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RPM_SHIFT      = 3'd0,
    REG_RPM_LOW        = 3'd1,
    REG_RPM_ACTIVATION = 3'd2,
    REG_RPM_STATIONARY = 3'd3,
    REG_ANIM_MODE      = 3'd4,
    REG_COLORS_12      = 3'd5,
    REG_COLORS_3_LOW   = 3'd6,
    REG_COLORS_FLASH   = 3'd7
  } cfg_reg_e;

  // Fill styles
  localparam logic [MODE_W-1:0] MODE_LTR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RTL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTWARD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INWARD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FULL    = 3'd4;

  // Frame class decided by the front end
  typedef enum logic [1:0] {
    K_SHIFT,
    K_LOW,
    K_BLANK,
    K_FILL
  } kind_e;

  // Segment of the color maps
  typedef enum logic [1:0] {
    SEG_1,
    SEG_2,
    SEG_3
  } seg_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [MS_W-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_t;

  typedef struct packed {
    logic [RPM_W-1:0]  rpm_shift;
    logic [RPM_W-1:0]  rpm_low;
    logic [RPM_W-1:0]  rpm_activation;
    logic [RPM_W-1:0]  rpm_stationary;
    logic [MODE_W-1:0] animation_mode;
    logic [CFG_W-1:0]  colors_part1_part2;
    logic [CFG_W-1:0]  colors_part3_low;
    logic [CFG_W-1:0]  colors_flash;
  } cfg_t;

  // Command queued between front and back: class plus low quotient bits
  // (bit 0 is the flash phase, all bits are the lit count for fill)
  typedef struct packed {
    kind_e            kind;
    logic [PIX_W-1:0] quo;
  } cmd_t;

endpackage

// ===== sv/rsl_div.sv =====
// Restoring divider, one quotient bit per cycle
module rsl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsl_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [rsl_pkg::DIVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [rsl_pkg::DIVD_W-1:0]  quo_o
);

  logic [rsl_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [rsl_pkg::DIVS_W-1:0] rem_q, rem_d;
  logic [rsl_pkg::DIVS_W-1:0] dvs_q, dvs_d;
  logic [rsl_pkg::DIVD_W-1:0] quo_q, quo_d;
  logic [rsl_pkg::DIVS_W:0]   trial;
  logic                       ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[rsl_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = rsl_pkg::DCNT_W'(rsl_pkg::DIVD_W);
      rem_d = '0;
      dvs_d = divisor_i;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? rsl_pkg::DIVS_W'(trial - {1'b0, dvs_q})
                 : trial[rsl_pkg::DIVS_W-1:0];
      quo_d = {quo_q[rsl_pkg::DIVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  // High in the cycle of the last step
  assign done_o = cnt_q == rsl_pkg::DCNT_W'(1);
  assign quo_o  = quo_q;

endmodule

// ===== sv/rsl_front.sv =====
// Front end: takes a request, classifies it, tracks arming, runs the divide for all but blank frames
module rsl_front #(
  parameter int NumLeds      = 16,
  parameter int FastFlashMs  = 100,
  parameter int TurboFlashMs = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rsl_pkg::in_t  in_data_i,
  input  rsl_pkg::cfg_t cfg_i,
  output logic          push_o,
  input  logic          full_i,
  output rsl_pkg::cmd_t cmd_o
);

  rsl_pkg::fe_state_e state_q, state_d;
  rsl_pkg::kind_e     kind_q, kind_d, kind_c;
  logic               armed_q, armed_d, armed_c;

  logic [rsl_pkg::RPM_W-1:0]  rpm;
  logic [rsl_pkg::RPM_W-1:0]  diff;
  logic [rsl_pkg::DIVD_W-1:0] dividend;
  logic [rsl_pkg::DIVS_W-1:0] divisor;
  logic [rsl_pkg::DIVD_W-1:0] quo;
  logic                       div_start;
  logic                       div_done;

  assign rpm  = in_data_i.rpm;
  assign diff = rpm - cfg_i.rpm_activation;

  // Classification in priority order, with the arming update
  always_comb begin
    kind_c  = rsl_pkg::K_FILL;
    armed_c = 1'b1;
    priority if (rpm >= cfg_i.rpm_shift) begin
      kind_c = rsl_pkg::K_SHIFT;
    end else if (armed_q && rpm <= cfg_i.rpm_low && rpm > cfg_i.rpm_stationary) begin
      kind_c  = rsl_pkg::K_LOW;
      armed_c = armed_q;
    end else if (rpm <= cfg_i.rpm_activation) begin
      kind_c = rsl_pkg::K_BLANK;
      priority if (rpm < cfg_i.rpm_stationary) armed_c = 1'b0;
      else if (rpm > cfg_i.rpm_low)            armed_c = 1'b1;
      else                                     armed_c = armed_q;
    end else begin
      kind_c = rsl_pkg::K_FILL;
    end
  end

  // Divider operands: flash period or fill ratio
  always_comb begin
    dividend = in_data_i.now_ms;
    divisor  = rsl_pkg::DIVS_W'(TurboFlashMs);
    unique case (kind_c)
      rsl_pkg::K_SHIFT: divisor = rsl_pkg::DIVS_W'(TurboFlashMs);
      rsl_pkg::K_LOW:   divisor = rsl_pkg::DIVS_W'(FastFlashMs);
      rsl_pkg::K_FILL: begin
        dividend = rsl_pkg::DIVD_W'(diff) * rsl_pkg::DIVD_W'(NumLeds);
        divisor  = cfg_i.rpm_shift - cfg_i.rpm_activation;
      end
      default: divisor = rsl_pkg::DIVS_W'(TurboFlashMs);
    endcase
  end

  // Control sequence
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    armed_d   = armed_q;
    div_start = 1'b0;
    push_o    = 1'b0;
    unique case (state_q)
      rsl_pkg::FE_IDLE: begin
        if (in_valid_i) begin
          kind_d    = kind_c;
          armed_d   = armed_c;
          div_start = kind_c != rsl_pkg::K_BLANK;
          state_d   = (kind_c == rsl_pkg::K_BLANK) ? rsl_pkg::FE_PUSH : rsl_pkg::FE_DIV;
        end
      end
      rsl_pkg::FE_DIV: begin
        if (div_done) state_d = rsl_pkg::FE_PUSH;
      end
      rsl_pkg::FE_PUSH: begin
        push_o = 1'b1;
        if (!full_i) state_d = rsl_pkg::FE_IDLE;
      end
      default: state_d = rsl_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsl_pkg::FE_IDLE;
      armed_q <= 1'b0;
      kind_q  <= rsl_pkg::K_BLANK;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      kind_q  <= kind_d;
    end
  end

  rsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign in_stall_o = state_q != rsl_pkg::FE_IDLE;
  assign cmd_o.kind = kind_q;
  assign cmd_o.quo  = quo[rsl_pkg::PIX_W-1:0];

endmodule

// ===== sv/rsl_fifo.sv =====
// Two-entry command queue between front and back
module rsl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsl_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rsl_pkg::cmd_t data_o
);

  rsl_pkg::cmd_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  assign data_o = mem_q[rd_q];

endmodule

// ===== sv/rsl_back.sv =====
// Back end: walks the bar one pixel per cycle into the output register while the output is not stalled
module rsl_back #(
  parameter int NumLeds = 16,
  parameter int Seg1Len = 6,
  parameter int Seg2Len = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsl_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  rsl_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rsl_pkg::out_t out_data_o
);

  // Halved map for the center styles
  localparam int Half  = (NumLeds + 1) / 2;
  localparam int H1Raw = (Seg1Len * Half) / NumLeds;
  localparam int H2Raw = (Seg2Len * Half) / NumLeds;
  localparam bit Tight = (H1Raw + H2Raw) == Half;
  localparam int H2Len = (Tight && H2Raw > 1) ? H2Raw - 1 : H2Raw;
  localparam int H1Len = (Tight && !(H2Raw > 1)) ? H1Raw - 1 : H1Raw;

  rsl_pkg::cmd_t               cmd_q;
  logic                        busy_q, busy_d;
  logic [rsl_pkg::PIX_W-1:0]   idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  rsl_pkg::out_t               out_q, out_d;

  logic [rsl_pkg::PIX_W-1:0]   mir;
  logic [rsl_pkg::COLOR_W-1:0] color;
  logic                        last;
  logic                        out_free;

  function automatic rsl_pkg::seg_e map_seg(int pos, int len1, int len2);
    rsl_pkg::seg_e s;
    if (pos < len1)             s = rsl_pkg::SEG_1;
    else if (pos < len1 + len2) s = rsl_pkg::SEG_2;
    else                        s = rsl_pkg::SEG_3;
    return s;
  endfunction

  function automatic logic [rsl_pkg::COLOR_W-1:0] seg_color(rsl_pkg::seg_e s,
                                                             rsl_pkg::cfg_t c);
    logic [rsl_pkg::COLOR_W-1:0] col;
    unique case (s)
      rsl_pkg::SEG_1: col = c.colors_part1_part2[47:24];
      rsl_pkg::SEG_2: col = c.colors_part1_part2[23:0];
      default:        col = c.colors_part3_low[47:24];
    endcase
    return col;
  endfunction

  assign mir  = (int'(idx_q) < Half) ? idx_q : rsl_pkg::PIX_W'(NumLeds - 1 - int'(idx_q));
  assign last = int'(idx_q) == NumLeds - 1;

  // Pixel color for the current position
  always_comb begin
    color = '0;
    unique case (cmd_q.kind)
      rsl_pkg::K_SHIFT:
        color = cmd_q.quo[0] ? cfg_i.colors_flash[47:24] : cfg_i.colors_flash[23:0];
      rsl_pkg::K_LOW:
        color = cmd_q.quo[0] ? cfg_i.colors_part3_low[23:0] : '0;
      rsl_pkg::K_BLANK:
        color = '0;
      default: begin
        unique case (cfg_i.animation_mode)
          rsl_pkg::MODE_RTL: begin
            if (int'(idx_q) + int'(cmd_q.quo) >= NumLeds - 1)
              color = seg_color(map_seg(NumLeds - 1 - int'(idx_q), Seg1Len, Seg2Len),
                                cfg_i);
          end
          rsl_pkg::MODE_OUTWARD: begin
            if (Half - ((int'(cmd_q.quo) + 2) >> 1) <= int'(mir))
              color = seg_color(map_seg(Half - 1 - int'(mir), H1Len, H2Len), cfg_i);
          end
          rsl_pkg::MODE_INWARD: begin
            if ((int'(cmd_q.quo) >> 1) >= int'(mir))
              color = seg_color(map_seg(int'(mir), H1Len, H2Len), cfg_i);
          end
          rsl_pkg::MODE_FULL: begin
            if (3 * int'(cmd_q.quo) >= 2 * NumLeds)  color = seg_color(rsl_pkg::SEG_3, cfg_i);
            else if (3 * int'(cmd_q.quo) >= NumLeds) color = seg_color(rsl_pkg::SEG_2, cfg_i);
            else                                     color = seg_color(rsl_pkg::SEG_1, cfg_i);
          end
          default: begin
            if (int'(cmd_q.quo) >= int'(idx_q))
              color = seg_color(map_seg(int'(idx_q), Seg1Len, Seg2Len), cfg_i);
          end
        endcase
      end
    endcase
  end

  // Pop a command when idle, emit one pixel whenever the output slot frees
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !busy_q && !empty_i;

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) out_valid_d = 1'b0;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && out_free) begin
      out_valid_d       = 1'b1;
      out_d.pixel_index = idx_q;
      out_d.pixel_color = color;
      out_d.last_pixel  = last;
      idx_d             = idx_q + 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) cmd_q <= cmd_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/rpm_shift_light_bar.sv =====
// An accepted request runs the 32-step serial divider in the front end before its
//   first pixel; a blank frame skips the divide. Then NUM_LEDS pixels follow back
//   to back unless stalled. The front end takes a new request only once the last
//   one's command is queued; blank frames are limited by the walk plus the pop.
// Reset (async, active low) restores register defaults, disarms the low
//   warning and empties the command queue and output register.
module rpm_shift_light_bar #(
  parameter int NUM_LEDS       = 16,
  parameter int SEG1_LEN       = 6,
  parameter int SEG2_LEN       = 5,
  parameter int FAST_FLASH_MS  = 100,
  parameter int TURBO_FLASH_MS = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rsl_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rsl_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rsl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rsl_pkg::CFG_W-1:0]       cfg_data_i
);

  rsl_pkg::cfg_t cfg_q, cfg_d;
  rsl_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, full, pop, empty;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rsl_pkg::cfg_reg_e'(cfg_idx_i))
        rsl_pkg::REG_RPM_SHIFT:      cfg_d.rpm_shift      = cfg_data_i[15:0];
        rsl_pkg::REG_RPM_LOW:        cfg_d.rpm_low        = cfg_data_i[15:0];
        rsl_pkg::REG_RPM_ACTIVATION: cfg_d.rpm_activation = cfg_data_i[15:0];
        rsl_pkg::REG_RPM_STATIONARY: cfg_d.rpm_stationary = cfg_data_i[15:0];
        rsl_pkg::REG_ANIM_MODE:
          cfg_d.animation_mode = cfg_data_i[rsl_pkg::MODE_W-1:0];
        rsl_pkg::REG_COLORS_12:      cfg_d.colors_part1_part2 = cfg_data_i;
        rsl_pkg::REG_COLORS_3_LOW:   cfg_d.colors_part3_low   = cfg_data_i;
        rsl_pkg::REG_COLORS_FLASH:   cfg_d.colors_flash       = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_shift          <= 16'd6000;
      cfg_q.rpm_low            <= 16'd2000;
      cfg_q.rpm_activation     <= 16'd3000;
      cfg_q.rpm_stationary     <= 16'd500;
      cfg_q.animation_mode     <= rsl_pkg::MODE_LTR;
      cfg_q.colors_part1_part2 <= '0;
      cfg_q.colors_part3_low   <= '0;
      cfg_q.colors_flash       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rsl_front #(
    .NumLeds      (NUM_LEDS),
    .FastFlashMs  (FAST_FLASH_MS),
    .TurboFlashMs (TURBO_FLASH_MS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (push_cmd)
  );

  rsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_cmd)
  );

  rsl_back #(
    .NumLeds (NUM_LEDS),
    .Seg1Len (SEG1_LEN),
    .Seg2Len (SEG2_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The last pixel of a frame always sits at the end of the bar
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_pixel |->
      out_data_o.pixel_index == rsl_pkg::PIX_W'(NUM_LEDS - 1))
    else $error("last pixel not at end of bar");

  // The front end takes one request at a time
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front end took a request while busy");

  // A frame streams without gaps once started
  a_frame_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_pixel |=> out_valid_o)
    else $error("gap inside a frame");

  // The back end pops the queue only when it holds a command
  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
